FILE: hdl/golden_section_minimizer_macros.svh
// ----------------------------------------------------------------------------
// golden section minimizer assertion macros
// concurrent assertion wrappers, empty when synthesising
// ----------------------------------------------------------------------------
`ifndef GOLDEN_SECTION_MINIMIZER_MACROS_SVH
`define GOLDEN_SECTION_MINIMIZER_MACROS_SVH

`ifndef SYNTHESIS

`define GSM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define GSM_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define GSM_ASSERT(label, clk, rst, prop, msg)

`define GSM_ASSERT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

FILE: hdl/gsm_pkg.sv
// ----------------------------------------------------------------------------
// gsm_pkg
// shared types, codes and constants of the golden section minimizer
// ----------------------------------------------------------------------------
`default_nettype none

package gsm_pkg;

   // signed q16.16 words, tolerance is an unsigned q0.32 word of the same width
   localparam int WORD_W      = 32;
   localparam int COUNT_W     = 16;
   localparam int CSR_INDEX_W = 2;

   typedef logic signed [WORD_W-1:0] word_type;

   localparam word_type WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

   // golden ratio constants, unsigned q0.32, sum is one
   localparam logic [WORD_W-1:0] GOLD_R = 32'd2654435769;
   localparam logic [WORD_W-1:0] GOLD_C = 32'd1640531527;

   localparam logic [CSR_INDEX_W-1:0] CSR_BRACKET_LOW  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BRACKET_MID  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BRACKET_HIGH = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOLERANCE    = 2'd3;

   localparam logic OP_START = 1'b0;
   localparam logic OP_VALUE = 1'b1;

   // operand and destination selection for one golden mix
   localparam logic [1:0] MODE_START_R = 2'd0;
   localparam logic [1:0] MODE_START_L = 2'd1;
   localparam logic [1:0] MODE_SIDE0   = 2'd2;
   localparam logic [1:0] MODE_SIDE1   = 2'd3;

   typedef struct packed {
      logic       start_load;
      logic       idle_value;
      logic       take_f1;
      logic       take_f2;
      logic       take_step;
      logic       side;
      logic       mul_tol;
      logic       mul_p;
      logic       check_tol;
      logic       step_begin;
      logic       mul_q;
      logic       mix;
      logic       load_rsp;
      logic [1:0] mode;
   } gsm_cmd_type;

   typedef struct packed {
      logic right_wider;
      logic f2_below_f1;
   } gsm_status_type;

endpackage

`default_nettype wire

FILE: hdl/gsm_req_if.sv
// ----------------------------------------------------------------------------
// gsm_req_if
// request channel: opcode and returned function value
// ----------------------------------------------------------------------------
`default_nettype none

interface gsm_req_if import gsm_pkg::*; ();

   logic     valid;
   logic     ready;
   logic     opcode;
   word_type function_value;

   modport source (output valid, output opcode, output function_value, input ready);
   modport sink   (input valid, input opcode, input function_value, output ready);

endinterface

`default_nettype wire

FILE: hdl/gsm_rsp_if.sv
// ----------------------------------------------------------------------------
// gsm_rsp_if
// response channel: next probe point and step status
// ----------------------------------------------------------------------------
`default_nettype none

interface gsm_rsp_if import gsm_pkg::*; ();

   logic               valid;
   logic               ready;
   word_type           probe_point;
   word_type           step_value;
   logic               step_valid;
   logic               tolerance_reached;
   logic [COUNT_W-1:0] eval_total;

   modport source (output valid, output probe_point, output step_value, output step_valid,
                   output tolerance_reached, output eval_total, input ready);
   modport sink   (input valid, input probe_point, input step_value, input step_valid,
                   input tolerance_reached, input eval_total, output ready);

endinterface

`default_nettype wire

FILE: hdl/gsm_dp.sv
// ----------------------------------------------------------------------------
// gsm_dp
// datapath: bracket registers, search points, shared multiplier, result register
// ----------------------------------------------------------------------------
`default_nettype none

module gsm_dp import gsm_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]      csr_wdata,
   input  word_type               function_value,
   input  gsm_cmd_type            cmd,
   output gsm_status_type         status,
   output word_type               probe_point,
   output word_type               step_value,
   output logic                   step_valid,
   output logic                   tolerance_reached,
   output logic [COUNT_W-1:0]     eval_total
);

   localparam logic [COUNT_W-1:0] TOL_MIN_STEPS = 16'd2;
   localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;

   function automatic logic [WORD_W-1:0] magnitude(input word_type x);
      return x[WORD_W-1] ? WORD_W'(-x) : WORD_W'(x);
   endfunction

   function automatic logic [WORD_W:0] distance(input word_type x, input word_type y);
      logic signed [WORD_W:0] d;
      d = $signed({x[WORD_W-1], x}) - $signed({y[WORD_W-1], y});
      return d[WORD_W] ? (WORD_W+1)'(-d) : (WORD_W+1)'(d);
   endfunction

   // nearest, ties away from zero
   function automatic logic signed [WORD_W:0] round_scale(input logic [2*WORD_W-1:0] prod,
                                                         input logic neg);
      logic [WORD_W:0] r;
      r = {1'b0, prod[2*WORD_W-1:WORD_W]} + {{WORD_W{1'b0}}, prod[WORD_W-1]};
      return neg ? -$signed(r) : $signed(r);
   endfunction

   word_type               bracket_low_ff, bracket_low_in;
   word_type               bracket_mid_ff, bracket_mid_in;
   word_type               bracket_high_ff, bracket_high_in;
   logic [WORD_W-1:0]      tol_ff, tol_in;

   word_type               outer_left_ff, outer_left_in;
   word_type               inner_left_ff, inner_left_in;
   word_type               inner_right_ff, inner_right_in;
   word_type               outer_right_ff, outer_right_in;
   word_type               value_left_ff, value_left_in;
   word_type               value_right_ff, value_right_in;
   logic [COUNT_W-1:0]     count_ff, count_in;

   logic [WORD_W:0]        lo_ff, lo_in;
   logic [WORD_W:0]        dist_ff, dist_in;
   logic [2*WORD_W-1:0]    prod_ff, prod_in;
   logic                   sign_p_ff, sign_p_in;
   logic                   sign_q_ff, sign_q_in;
   logic signed [WORD_W:0] sp_ff, sp_in;

   word_type               res_probe_ff, res_probe_in;
   word_type               res_value_ff, res_value_in;
   logic                   res_valid_ff, res_valid_in;
   logic                   res_tol_ff, res_tol_in;

   word_type               rsp_probe_ff, rsp_probe_in;
   word_type               rsp_value_ff, rsp_value_in;
   logic                   rsp_step_ff, rsp_step_in;
   logic                   rsp_tol_ff, rsp_tol_in;
   logic [COUNT_W-1:0]     rsp_count_ff, rsp_count_in;

   word_type               op_p, op_q;
   logic [WORD_W-1:0]      mul_a, mul_b;
   logic signed [WORD_W:0] sq;
   logic signed [WORD_W+1:0] mix_sum;
   word_type               mix_word;
   logic [WORD_W:0]        tol_rhs;

   assign status.right_wider = distance(bracket_high_ff, bracket_mid_ff) >
                               distance(bracket_mid_ff, bracket_low_ff);
   assign status.f2_below_f1 = value_right_ff < value_left_ff;

   // configuration
   always_comb begin
      bracket_low_in  = bracket_low_ff;
      bracket_mid_in  = bracket_mid_ff;
      bracket_high_in = bracket_high_ff;
      tol_in          = tol_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_BRACKET_LOW:  bracket_low_in  = csr_wdata;
            CSR_BRACKET_MID:  bracket_mid_in  = csr_wdata;
            CSR_BRACKET_HIGH: bracket_high_in = csr_wdata;
            CSR_TOLERANCE:    tol_in          = csr_wdata;
            default:          tol_in          = tol_ff;
         endcase
      end
   end

   always_comb begin
      case (cmd.mode)
         MODE_START_R: begin
            op_p = inner_left_ff;
            op_q = outer_right_ff;
         end
         MODE_START_L: begin
            op_p = inner_right_ff;
            op_q = outer_left_ff;
         end
         MODE_SIDE0: begin
            op_p = inner_right_ff;
            op_q = outer_right_ff;
         end
         MODE_SIDE1: begin
            op_p = inner_left_ff;
            op_q = outer_left_ff;
         end
         default: begin
            op_p = '0;
            op_q = '0;
         end
      endcase
   end

   // shared multiplier
   always_comb begin
      if (cmd.mul_tol) begin
         mul_a = lo_ff[WORD_W-1:0];
         mul_b = tol_ff;
      end else if (cmd.mul_p) begin
         mul_a = magnitude(op_p);
         mul_b = GOLD_R;
      end else if (cmd.mul_q) begin
         mul_a = magnitude(op_q);
         mul_b = GOLD_C;
      end else begin
         mul_a = '0;
         mul_b = '0;
      end
      prod_in = mul_a * mul_b;
   end

   always_comb begin
      sq      = round_scale(prod_ff, sign_q_ff);
      mix_sum = $signed({sp_ff[WORD_W], sp_ff}) + $signed({sq[WORD_W], sq});
      if (mix_sum > $signed({2'b00, WORD_MAX})) begin
         mix_word = WORD_MAX;
      end else if (mix_sum < $signed({2'b11, WORD_MIN})) begin
         mix_word = WORD_MIN;
      end else begin
         mix_word = mix_sum[WORD_W-1:0];
      end
      tol_rhs = lo_ff[WORD_W] ? {1'b0, tol_ff} : {1'b0, prod_ff[2*WORD_W-1:WORD_W]};
   end

   always_comb begin
      outer_left_in  = outer_left_ff;
      inner_left_in  = inner_left_ff;
      inner_right_in = inner_right_ff;
      outer_right_in = outer_right_ff;
      value_left_in  = value_left_ff;
      value_right_in = value_right_ff;
      count_in       = count_ff;
      lo_in          = lo_ff;
      dist_in        = dist_ff;
      sign_p_in      = sign_p_ff;
      sign_q_in      = sign_q_ff;
      sp_in          = sp_ff;
      res_probe_in   = res_probe_ff;
      res_value_in   = res_value_ff;
      res_valid_in   = res_valid_ff;
      res_tol_in     = res_tol_ff;

      if (cmd.start_load) begin
         outer_left_in  = bracket_low_ff;
         outer_right_in = bracket_high_ff;
         if (status.right_wider) begin
            inner_left_in = bracket_mid_ff;
         end else begin
            inner_right_in = bracket_mid_ff;
         end
         count_in     = '0;
         res_value_in = '0;
         res_valid_in = 1'b0;
         res_tol_in   = 1'b0;
      end

      if (cmd.idle_value) begin
         res_probe_in = '0;
         res_value_in = '0;
         res_valid_in = 1'b0;
         res_tol_in   = 1'b0;
      end

      if (cmd.take_f1) begin
         value_left_in = function_value;
         res_probe_in  = inner_right_ff;
         res_value_in  = '0;
         res_valid_in  = 1'b0;
         res_tol_in    = 1'b0;
      end

      if (cmd.take_f2) begin
         value_right_in = function_value;
         res_value_in   = '0;
         res_valid_in   = 1'b0;
         res_tol_in     = 1'b0;
      end

      if (cmd.take_step) begin
         if (cmd.side) begin
            value_right_in = value_left_ff;
            value_left_in  = function_value;
         end else begin
            value_left_in  = value_right_ff;
            value_right_in = function_value;
         end
         lo_in        = {1'b0, magnitude(inner_left_ff)} + {1'b0, magnitude(inner_right_ff)};
         dist_in      = distance(outer_right_ff, outer_left_ff);
         res_value_in = function_value;
         res_valid_in = 1'b1;
         res_tol_in   = 1'b0;
      end

      if (cmd.mul_p) begin
         sign_p_in = op_p[WORD_W-1];
         if (cmd.check_tol) begin
            res_tol_in = (count_ff > TOL_MIN_STEPS) && (dist_ff <= tol_rhs);
         end
         if (cmd.step_begin && count_ff != COUNT_MAX) begin
            count_in = count_ff + 1'b1;
         end
      end

      if (cmd.mul_q) begin
         sp_in     = round_scale(prod_ff, sign_p_ff);
         sign_q_in = op_q[WORD_W-1];
      end

      if (cmd.mix) begin
         res_probe_in = mix_word;
         case (cmd.mode)
            MODE_START_R: begin
               inner_right_in = mix_word;
               res_probe_in   = inner_left_ff;
            end
            MODE_START_L: begin
               inner_left_in = mix_word;
            end
            MODE_SIDE0: begin
               outer_left_in  = inner_left_ff;
               inner_left_in  = inner_right_ff;
               inner_right_in = mix_word;
            end
            MODE_SIDE1: begin
               outer_right_in = inner_right_ff;
               inner_right_in = inner_left_ff;
               inner_left_in  = mix_word;
            end
            default: begin
               res_probe_in = mix_word;
            end
         endcase
      end
   end

   always_comb begin
      rsp_probe_in = rsp_probe_ff;
      rsp_value_in = rsp_value_ff;
      rsp_step_in  = rsp_step_ff;
      rsp_tol_in   = rsp_tol_ff;
      rsp_count_in = rsp_count_ff;
      if (cmd.load_rsp) begin
         rsp_probe_in = res_probe_ff;
         rsp_value_in = res_value_ff;
         rsp_step_in  = res_valid_ff;
         rsp_tol_in   = res_tol_ff;
         rsp_count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bracket_low_ff  <= '0;
         bracket_mid_ff  <= '0;
         bracket_high_ff <= '0;
         tol_ff          <= '0;
         count_ff        <= '0;
      end else begin
         bracket_low_ff  <= bracket_low_in;
         bracket_mid_ff  <= bracket_mid_in;
         bracket_high_ff <= bracket_high_in;
         tol_ff          <= tol_in;
         count_ff        <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      outer_left_ff  <= outer_left_in;
      inner_left_ff  <= inner_left_in;
      inner_right_ff <= inner_right_in;
      outer_right_ff <= outer_right_in;
      value_left_ff  <= value_left_in;
      value_right_ff <= value_right_in;
      lo_ff          <= lo_in;
      dist_ff        <= dist_in;
      prod_ff        <= prod_in;
      sign_p_ff      <= sign_p_in;
      sign_q_ff      <= sign_q_in;
      sp_ff          <= sp_in;
      res_probe_ff   <= res_probe_in;
      res_value_ff   <= res_value_in;
      res_valid_ff   <= res_valid_in;
      res_tol_ff     <= res_tol_in;
      rsp_probe_ff   <= rsp_probe_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_step_ff    <= rsp_step_in;
      rsp_tol_ff     <= rsp_tol_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign probe_point       = rsp_probe_ff;
   assign step_value        = rsp_value_ff;
   assign step_valid        = rsp_step_ff;
   assign tolerance_reached = rsp_tol_ff;
   assign eval_total        = rsp_count_ff;

endmodule

`default_nettype wire

FILE: hdl/gsm_ctrl.sv
// ----------------------------------------------------------------------------
// gsm_ctrl
// controller: search phase, step sequencing and response handshake
// ----------------------------------------------------------------------------
`default_nettype none

`include "golden_section_minimizer_macros.svh"

module gsm_ctrl import gsm_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  logic           req_opcode,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  gsm_status_type status,
   output gsm_cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_TOL   = 3'd1;
   localparam logic [2:0] ST_MUL_P = 3'd2;
   localparam logic [2:0] ST_MUL_Q = 3'd3;
   localparam logic [2:0] ST_MIX   = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   localparam logic [1:0] PH_IDLE        = 2'd0;
   localparam logic [1:0] PH_AWAIT_F1    = 2'd1;
   localparam logic [1:0] PH_AWAIT_F2    = 2'd2;
   localparam logic [1:0] PH_AWAIT_PROBE = 2'd3;

   logic [2:0] state_ff, state_in;
   logic [1:0] phase_ff, phase_in;
   logic [1:0] mode_ff, mode_in;
   logic       pending_side_ff, pending_side_in;
   logic       step_ff, step_in;
   logic       check_ff, check_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in        = state_ff;
      phase_in        = phase_ff;
      mode_in         = mode_ff;
      pending_side_in = pending_side_ff;
      step_in         = step_ff;
      check_in        = check_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      cmd             = '0;
      cmd.mode        = mode_ff;
      cmd.side        = pending_side_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_opcode == OP_START) begin
                  cmd.start_load = 1'b1;
                  mode_in  = status.right_wider ? MODE_START_R : MODE_START_L;
                  step_in  = 1'b0;
                  check_in = 1'b0;
                  phase_in = PH_AWAIT_F1;
                  state_in = ST_MUL_P;
               end else begin
                  case (phase_ff)
                     PH_AWAIT_F1: begin
                        cmd.take_f1 = 1'b1;
                        phase_in    = PH_AWAIT_F2;
                        state_in    = ST_DONE;
                     end
                     PH_AWAIT_F2: begin
                        cmd.take_f2 = 1'b1;
                        step_in     = 1'b1;
                        check_in    = 1'b0;
                        phase_in    = PH_AWAIT_PROBE;
                        state_in    = ST_MUL_P;
                     end
                     PH_AWAIT_PROBE: begin
                        cmd.take_step = 1'b1;
                        step_in       = 1'b1;
                        check_in      = 1'b1;
                        state_in      = ST_TOL;
                     end
                     default: begin
                        cmd.idle_value = 1'b1;
                        state_in       = ST_DONE;
                     end
                  endcase
               end
            end
         end
         ST_TOL: begin
            cmd.mul_tol = 1'b1;
            state_in    = ST_MUL_P;
         end
         ST_MUL_P: begin
            cmd.mul_p      = 1'b1;
            cmd.check_tol  = check_ff;
            cmd.step_begin = step_ff;
            if (step_ff) begin
               cmd.mode        = status.f2_below_f1 ? MODE_SIDE0 : MODE_SIDE1;
               pending_side_in = !status.f2_below_f1;
            end
            mode_in  = cmd.mode;
            state_in = ST_MUL_Q;
         end
         ST_MUL_Q: begin
            cmd.mul_q = 1'b1;
            state_in  = ST_MIX;
         end
         ST_MIX: begin
            cmd.mix  = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         phase_ff        <= PH_IDLE;
         mode_ff         <= MODE_START_R;
         pending_side_ff <= 1'b0;
         step_ff         <= 1'b0;
         check_ff        <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         phase_ff        <= phase_in;
         mode_ff         <= mode_in;
         pending_side_ff <= pending_side_in;
         step_ff         <= step_in;
         check_ff        <= check_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `GSM_ASSERT(a_start_arms, clock, reset, (state_ff == ST_IDLE && req_valid && req_opcode == OP_START) |=> (phase_ff == PH_AWAIT_F1), "start transaction did not arm the first probe")

   `GSM_ASSERT(a_mix_sequence, clock, reset, (state_ff == ST_MUL_P) |=> (state_ff == ST_MUL_Q) ##1 (state_ff == ST_MIX), "golden mix sequence broken")

   `GSM_ASSERT(a_side_matches, clock, reset, (state_ff == ST_MUL_Q && step_ff) |-> (pending_side_ff == (mode_ff == MODE_SIDE1)), "pending side disagrees with mix mode")

   `GSM_ASSERT(a_done_drains, clock, reset, (state_ff == ST_DONE && !rsp_valid_ff) |=> (state_ff == ST_IDLE && rsp_valid_ff), "finished transaction not handed to response register")

   `GSM_ASSERT_NEVER(a_check_needs_step, clock, reset, check_ff && !step_ff && state_ff != ST_IDLE, "tolerance check outside a search step")

endmodule

`default_nettype wire

FILE: hdl/golden_section_minimizer.sv
// ----------------------------------------------------------------------------
// golden_section_minimizer
// golden section search over an externally evaluated function, q16.16
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake              payload
//   req_ch    in    valid/ready            opcode, function_value
//   rsp_ch    out   valid/ready            probe_point, step_value, step_valid,
//                                          tolerance_reached, eval_total
//   csr_*     in    write enable, no wait  csr_index, csr_wdata
//
// a value before a search or the first value goes straight to the done state; a start or
// the second value runs both golden products and the mix, every further value the
// tolerance product first; all share the single 32x32 multiplier, one at a time.
// synchronous reset clears the controller, step counter, bracket and tolerance registers.
// a new transaction is accepted while a result still waits on rsp_ch; the next
// result waits until the response register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module golden_section_minimizer import gsm_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   gsm_req_if.sink                req_ch,
   gsm_rsp_if.source              rsp_ch,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]      csr_wdata
);

   gsm_cmd_type    cmd;
   gsm_status_type status;

   gsm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_ready  (req_ch.ready),
      .req_opcode (req_ch.opcode),
      .rsp_valid  (rsp_ch.valid),
      .rsp_ready  (rsp_ch.ready),
      .status     (status),
      .cmd        (cmd)
   );

   gsm_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .function_value    (req_ch.function_value),
      .cmd               (cmd),
      .status            (status),
      .probe_point       (rsp_ch.probe_point),
      .step_value        (rsp_ch.step_value),
      .step_valid        (rsp_ch.step_valid),
      .tolerance_reached (rsp_ch.tolerance_reached),
      .eval_total        (rsp_ch.eval_total)
   );

endmodule

`default_nettype wire

FILE: tb/tb_golden_section_minimizer.sv
// ----------------------------------------------------------------------------
// tb_golden_section_minimizer
// self-checking bench: a table of directed transactions, then random searches
// against a golden-section predictor; both channels idle and stall at random
// in turns
// ----------------------------------------------------------------------------
`default_nettype none

module tb_golden_section_minimizer;
   import gsm_pkg::*;

   typedef struct packed {
      word_type           probe;
      word_type           value;
      logic               valid;
      logic               reached;
      logic [COUNT_W-1:0] total;
   } search_result_type;

   typedef struct packed {
      word_type          low;
      word_type          mid;
      word_type          high;
      logic [WORD_W-1:0] tol;
   } bracket_type;

   typedef struct packed {
      int                setup;
      logic              opcode;
      word_type          fvalue;
      logic              typed;
      search_result_type known;
   } directed_row_type;

   typedef enum logic [1:0] {PH_IDLE, PH_WAIT_F1, PH_WAIT_F2, PH_WAIT_PROBE} search_phase_type;

   localparam int       KEEP       = -1;
   localparam int       IDLE_LIMIT = 1000;
   localparam int       SETTLE     = 8;
   localparam int       PHASES     = 12;
   localparam int       PHASE_LEN  = 115;
   localparam word_type ZERO_WORD  = '0;

   localparam int       SEND_IDLE [4] = '{0, 54, 0, 6};
   localparam int       RECV_STALL [4] = '{0, 0, 54, 6};
   localparam word_type CORNERS [4] = '{WORD_MIN, WORD_MAX, ZERO_WORD, -32'sd1};

   localparam bracket_type DIRECTED_SETUPS [4] = '{
      '{WORD_MIN, ZERO_WORD, WORD_MAX, 32'hFFFF_FFFF},
      '{WORD_MIN, WORD_MIN, WORD_MIN, 32'h0000_0000},
      '{WORD_MAX, ZERO_WORD, WORD_MIN, 32'h8000_0000},
      '{32'shFFFE_0000, 32'sh0000_8000, 32'sh0003_0000, 32'h0400_0000}
   };

   localparam directed_row_type DIRECTED_ROWS [25] = '{
      '{KEEP, OP_VALUE, WORD_MAX, 1'b1, '{ZERO_WORD, ZERO_WORD, 1'b0, 1'b0, 16'd0}},
      '{KEEP, OP_VALUE, WORD_MIN, 1'b1, '{ZERO_WORD, ZERO_WORD, 1'b0, 1'b0, 16'd0}},
      '{KEEP, OP_START, ZERO_WORD, 1'b1, '{ZERO_WORD, ZERO_WORD, 1'b0, 1'b0, 16'd0}},
      '{KEEP, OP_VALUE, 32'sd5, 1'b1, '{ZERO_WORD, ZERO_WORD, 1'b0, 1'b0, 16'd0}},
      '{KEEP, OP_VALUE, 32'sd5, 1'b1, '{ZERO_WORD, ZERO_WORD, 1'b0, 1'b0, 16'd1}},
      '{KEEP, OP_VALUE, WORD_MIN, 1'b1, '{ZERO_WORD, WORD_MIN, 1'b1, 1'b0, 16'd2}},
      '{KEEP, OP_VALUE, WORD_MAX, 1'b1, '{ZERO_WORD, WORD_MAX, 1'b1, 1'b0, 16'd3}},
      '{KEEP, OP_VALUE, ZERO_WORD, 1'b1, '{ZERO_WORD, ZERO_WORD, 1'b1, 1'b1, 16'd4}},
      '{0, OP_START, 32'sh1234_5678, 1'b0, '0},
      '{KEEP, OP_VALUE, WORD_MAX, 1'b0, '0},
      '{KEEP, OP_VALUE, WORD_MIN, 1'b0, '0},
      '{KEEP, OP_VALUE, ZERO_WORD, 1'b0, '0},
      '{KEEP, OP_VALUE, ZERO_WORD, 1'b0, '0},
      '{KEEP, OP_VALUE, 32'sd1, 1'b0, '0},
      '{KEEP, OP_VALUE, -32'sd1, 1'b0, '0},
      '{KEEP, OP_START, -32'sd1, 1'b0, '0},
      '{KEEP, OP_VALUE, 32'sh0001_0000, 1'b0, '0},
      '{1, OP_START, ZERO_WORD, 1'b1, '{WORD_MIN, ZERO_WORD, 1'b0, 1'b0, 16'd0}},
      '{KEEP, OP_VALUE, 32'sd3, 1'b1, '{WORD_MIN, ZERO_WORD, 1'b0, 1'b0, 16'd0}},
      '{KEEP, OP_VALUE, 32'sd3, 1'b0, '0},
      '{2, OP_START, ZERO_WORD, 1'b0, '0},
      '{KEEP, OP_VALUE, -32'sd5, 1'b0, '0},
      '{KEEP, OP_VALUE, 32'sd7, 1'b0, '0},
      '{3, OP_START, ZERO_WORD, 1'b0, '0},
      '{KEEP, OP_VALUE, 32'sd7, 1'b0, '0}
   };

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [WORD_W-1:0]      csr_wdata;

   gsm_req_if req_ch ();
   gsm_rsp_if rsp_ch ();

   golden_section_minimizer i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor state and its copy of the registers
   word_type           outer_lo, inner_lo, inner_hi, outer_hi;
   word_type           val_lo, val_hi;
   search_phase_type   phase;
   logic               probe_is_left;
   logic [COUNT_W-1:0] steps;
   word_type           cfg_low, cfg_mid, cfg_high;
   logic [WORD_W-1:0]  cfg_tol;

   search_result_type awaited_results [$];
   word_type          last_probe;
   word_type          valley;
   int                items_sent;
   int                mismatches;
   int                quiet_cycles;
   int                send_idle_pct;
   int                stall_pct;

   always #5 clock = ~clock;

   // round(x * k / 2^32), ties away from zero
   function automatic longint gold_scale(input word_type x, input logic [WORD_W-1:0] k);
      logic [63:0] mag;
      logic [63:0] prod;
      mag  = (x < 0) ? 64'(-longint'(x)) : 64'(longint'(x));
      prod = (mag * 64'(k) + 64'h8000_0000) >> 32;
      return (x < 0) ? -longint'(prod) : longint'(prod);
   endfunction

   function automatic word_type golden_blend(input word_type p, input word_type q);
      longint s;
      s = gold_scale(p, GOLD_R) + gold_scale(q, GOLD_C);
      if (s > longint'(WORD_MAX)) return WORD_MAX;
      if (s < longint'(WORD_MIN)) return WORD_MIN;
      return word_type'(s);
   endfunction

   function automatic longint span(input word_type x, input word_type y);
      longint d;
      d = longint'(x) - longint'(y);
      return (d < 0) ? -d : d;
   endfunction

   function automatic logic interval_converged();
      logic [63:0] width;
      logic [63:0] sum;
      logic [63:0] limit;
      width = 64'(span(outer_hi, outer_lo));
      sum   = 64'(span(inner_lo, ZERO_WORD)) + 64'(span(inner_hi, ZERO_WORD));
      limit = 64'(cfg_tol) * (sum >> 32) + ((64'(cfg_tol) * 64'(sum[31:0])) >> 32);
      return width <= limit;
   endfunction

   function automatic word_type shrink_bracket();
      if (steps != '1) steps++;
      if (val_hi < val_lo) begin
         outer_lo      = inner_lo;
         inner_lo      = inner_hi;
         inner_hi      = golden_blend(inner_lo, outer_hi);
         probe_is_left = 1'b0;
         return inner_hi;
      end
      outer_hi      = inner_hi;
      inner_hi      = inner_lo;
      inner_lo      = golden_blend(inner_hi, outer_lo);
      probe_is_left = 1'b1;
      return inner_lo;
   endfunction

   function automatic search_result_type search_step(input logic op, input word_type v);
      search_result_type r;
      r = '0;
      if (op == OP_START) begin
         steps    = '0;
         outer_lo = cfg_low;
         outer_hi = cfg_high;
         if (span(cfg_high, cfg_mid) > span(cfg_mid, cfg_low)) begin
            inner_lo = cfg_mid;
            inner_hi = golden_blend(cfg_mid, cfg_high);
         end else begin
            inner_hi = cfg_mid;
            inner_lo = golden_blend(cfg_mid, cfg_low);
         end
         phase   = PH_WAIT_F1;
         r.probe = inner_lo;
      end else begin
         case (phase)
            PH_WAIT_F1: begin
               val_lo  = v;
               phase   = PH_WAIT_F2;
               r.probe = inner_hi;
            end
            PH_WAIT_F2: begin
               val_hi  = v;
               phase   = PH_WAIT_PROBE;
               r.probe = shrink_bracket();
            end
            PH_WAIT_PROBE: begin
               if (probe_is_left) begin
                  val_hi = val_lo;
                  val_lo = v;
               end else begin
                  val_lo = val_hi;
                  val_hi = v;
               end
               r.value   = v;
               r.valid   = 1'b1;
               r.reached = (steps > 2) && interval_converged();
               r.probe   = shrink_bracket();
            end
            default: ;
         endcase
      end
      r.total = steps;
      return r;
   endfunction

   // mostly a v-shaped function around the valley, so the search really converges
   function automatic word_type sample_value();
      longint gap;
      gap = span(last_probe, valley);
      case ($urandom_range(9))
         0: return word_type'($urandom);
         1: return word_type'($urandom_range(3));
         2: return $urandom_range(1) ? WORD_MAX : WORD_MIN;
         3: return (gap > longint'(WORD_MAX)) ? WORD_MIN : word_type'(-gap);
         default: return (gap > longint'(WORD_MAX)) ? WORD_MAX : word_type'(gap);
      endcase
   endfunction

   task automatic issue(input logic op, input word_type fval, input logic typed,
                        input search_result_type known);
      search_result_type predicted;
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.opcode         <= op;
      req_ch.function_value <= fval;
      do @(posedge clock); while (!req_ch.ready);
      predicted  = search_step(op, fval);
      last_probe = predicted.probe;
      awaited_results.push_back(typed ? known : predicted);
      items_sent++;
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic load_bracket(input bracket_type b);
      drain();
      csr_we    <= 1'b1;
      csr_index <= CSR_BRACKET_LOW;
      csr_wdata <= b.low;
      @(posedge clock);
      csr_index <= CSR_BRACKET_MID;
      csr_wdata <= b.mid;
      @(posedge clock);
      csr_index <= CSR_BRACKET_HIGH;
      csr_wdata <= b.high;
      @(posedge clock);
      csr_index <= CSR_TOLERANCE;
      csr_wdata <= b.tol;
      @(posedge clock);
      csr_we   <= 1'b0;
      cfg_low  = b.low;
      cfg_mid  = b.mid;
      cfg_high = b.high;
      cfg_tol  = b.tol;
   endtask

   always @(posedge clock) begin
      rsp_ch.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin : check_results
      search_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (awaited_results.size() == 0) begin
            $error("result transaction with none outstanding, probe_point %0d",
                   rsp_ch.probe_point);
            mismatches++;
         end else begin
            want = awaited_results.pop_front();
            if (rsp_ch.probe_point !== want.probe) begin
               $error("probe_point: expected %0d, got %0d", want.probe, rsp_ch.probe_point);
               mismatches++;
            end
            if (rsp_ch.step_value !== want.value) begin
               $error("step_value: expected %0d, got %0d", want.value, rsp_ch.step_value);
               mismatches++;
            end
            if (rsp_ch.step_valid !== want.valid) begin
               $error("step_valid: expected %0d, got %0d", want.valid, rsp_ch.step_valid);
               mismatches++;
            end
            if (rsp_ch.tolerance_reached !== want.reached) begin
               $error("tolerance_reached: expected %0d, got %0d", want.reached,
                      rsp_ch.tolerance_reached);
               mismatches++;
            end
            if (rsp_ch.eval_total !== want.total) begin
               $error("eval_total: expected %0d, got %0d", want.total, rsp_ch.eval_total);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      bracket_type setup;
      word_type    held;
      longint      centre;
      longint      lo_w;
      longint      hi_w;
      int          phase_end;
      int          run_len;

      req_ch.valid          = 1'b0;
      req_ch.opcode         = OP_START;
      req_ch.function_value = '0;
      rsp_ch.ready          = 1'b0;
      csr_we                = 1'b0;
      csr_index             = CSR_BRACKET_LOW;
      csr_wdata             = '0;
      quiet_cycles          = 0;
      mismatches            = 0;
      items_sent            = 0;
      send_idle_pct         = 6;
      stall_pct             = 6;
      outer_lo = '0; inner_lo = '0; inner_hi = '0; outer_hi = '0;
      val_lo = '0; val_hi = '0;
      phase = PH_IDLE; probe_is_left = 1'b0; steps = '0;
      cfg_low = '0; cfg_mid = '0; cfg_high = '0; cfg_tol = '0;
      last_probe = '0; valley = '0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
         if (DIRECTED_ROWS[i].setup != KEEP)
            load_bracket(DIRECTED_SETUPS[DIRECTED_ROWS[i].setup]);
         issue(DIRECTED_ROWS[i].opcode, DIRECTED_ROWS[i].fvalue, DIRECTED_ROWS[i].typed,
               DIRECTED_ROWS[i].known);
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         send_idle_pct = SEND_IDLE[ph % 4];
         stall_pct     = RECV_STALL[ph % 4];
         case ($urandom_range(5))
            0: setup = '{word_type'($urandom), word_type'($urandom), word_type'($urandom),
                         $urandom};
            1: setup = '{CORNERS[$urandom_range(3)], CORNERS[$urandom_range(3)],
                         CORNERS[$urandom_range(3)], $urandom_range(1) ? '1 : '0};
            default: begin
               centre     = longint'($urandom_range(1 << 23)) - (1 << 22);
               lo_w       = $urandom_range(1 << 20, 1);
               hi_w       = $urandom_range(1 << 20, 1);
               setup.low  = word_type'(centre - lo_w);
               setup.mid  = word_type'(centre);
               setup.high = word_type'(centre + hi_w);
               // occasionally a bracket given high to low
               if ($urandom_range(4) == 0) begin
                  held       = setup.low;
                  setup.low  = setup.high;
                  setup.high = held;
               end
               setup.tol = ($urandom_range(3) == 0) ? $urandom
                                                    : 32'(1) << $urandom_range(31, 8);
            end
         endcase
         load_bracket(setup);
         phase_end = items_sent + PHASE_LEN;
         while (items_sent < phase_end) begin
            valley  = word_type'(longint'(cfg_mid) + longint'($urandom_range(1 << 16))
                                 - (1 << 15));
            run_len = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(40, 3);
            issue(OP_START, word_type'($urandom), 1'b0, '0);
            repeat (run_len) issue(OP_VALUE, sample_value(), 1'b0, '0);
         end
      end

      drain();
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+hdl
hdl/gsm_pkg.sv
hdl/gsm_req_if.sv
hdl/gsm_rsp_if.sv
hdl/gsm_dp.sv
hdl/gsm_ctrl.sv
hdl/golden_section_minimizer.sv
tb/tb_golden_section_minimizer.sv
